// ----- rtl/rn48_pkg.sv -----
// shared types, codes and constants of the node48 child table
package rn48_pkg;

    localparam int SLOTS_DEF    = 48;
    localparam int MIN_FILL_DEF = 12;
    localparam int KEY_SPACE    = 256;

    localparam int OP_W     = 3;
    localparam int KEY_W    = 8;
    localparam int CHILD_W  = 48;
    localparam int STATUS_W = 2;

    localparam int IN_TDATA_W  = 64;
    localparam int OUT_TDATA_W = 64;
    localparam int IN_USED_W   = KEY_W + CHILD_W + 1;
    localparam int OUT_USED_W  = STATUS_W + 1 + KEY_W + CHILD_W;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 3'd0,
        OP_CHANGE = 3'd1,
        OP_REMOVE = 3'd2,
        OP_LOOKUP = 3'd3,
        OP_MIN_GE = 3'd4,
        OP_MAX_LE = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_ABSENT   = 2'd2,
        STAT_MIN_FILL = 2'd3
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic commit_point;
        logic commit_hit;
        logic commit_miss;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic point_op;
        logic present;
        logic at_end;
        logic child_nz;
        logic out_free;
    } t_sts;

endpackage

// ----- rtl/radix_node48_child_table.sv -----
// top level of the node48 child table
//
// keyed child table of a 48-way radix tree node: a 256-entry key index points into
// child slots that are handed out in order and never reused
// input channel: one item per operation; s_tuser carries the opcode, s_tdata the key,
// the child reference and the force flag
// output channel: exactly one result item per input item, in order
// one item is in work at a time; s_tready is high only while the sequencer is idle
// steps from the accepted item to the registered result:
//   insert, change, remove, unused opcodes: index read, then decision and commit
//   lookup: index read, then a slot read when the key is present
//   searches: an index read per key and a slot read per key with an entry, up to the hit
//   or the end of the key range
// a point operation takes one index read, then the decision and the slot write;
// searches are bounded by the serial index/slot walk
// results sit in an output register, so a stalled receiver holds at most one result;
// the next item is taken but its result waits until the register is free
// synchronous reset empties the index (valid bits) and zeroes the counters; the slot
// store keeps its contents, which are read only through live index entries
module radix_node48_child_table #(
    parameter int SLOTS    = rn48_pkg::SLOTS_DEF,
    parameter int MIN_FILL = rn48_pkg::MIN_FILL_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key [7:0], child_ref [55:8], force_req [56], zero [63:57]
    input  logic [rn48_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op [2:0]
    input  logic [rn48_pkg::OP_W-1:0]           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status [1:0], found [2], found_key [10:3], found_child [58:11], zero [63:59]
    output logic [rn48_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import rn48_pkg::*;

    localparam int OUT_PAD = OUT_TDATA_W - OUT_USED_W;

    t_cmd                cmd;
    t_sts                sts;
    logic [STATUS_W-1:0] status;
    logic                found;
    logic [KEY_W-1:0]    found_key;
    logic [CHILD_W-1:0]  found_child;

    rn48_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rn48_dp #(
        .SLOTS    (SLOTS),
        .MIN_FILL (MIN_FILL)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_op          (s_axis_tuser),
        .i_key         (s_axis_tdata[KEY_W-1:0]),
        .i_child       (s_axis_tdata[KEY_W +: CHILD_W]),
        .i_force       (s_axis_tdata[KEY_W + CHILD_W]),
        .i_out_ready   (m_axis_tready),
        .o_sts         (sts),
        .o_out_valid   (m_axis_tvalid),
        .o_status      (status),
        .o_found       (found),
        .o_found_key   (found_key),
        .o_found_child (found_child)
    );

    assign m_axis_tdata = {{OUT_PAD{1'b0}}, found_child, found_key, found, status};

endmodule

// ----- rtl/rn48_ctrl.sv -----
// sequencer of the node48 child table: index read, slot read, scan steps, result commit
module rn48_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    input  rn48_pkg::t_sts  i_sts,
    output rn48_pkg::t_cmd  o_cmd
);
    import rn48_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_INDEX,
        S_SLOT
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    cmd.load = 1'b1;
                    n_state  = S_INDEX;
                end
            end
            S_INDEX: begin
                if (i_sts.point_op) begin
                    if (i_sts.out_free) begin
                        cmd.commit_point = 1'b1;
                        n_state          = S_IDLE;
                    end
                end else if (i_sts.present) begin
                    n_state = S_SLOT;
                end else if (i_sts.at_end) begin
                    if (i_sts.out_free) begin
                        cmd.commit_miss = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    cmd.step = 1'b1;
                end
            end
            S_SLOT: begin
                if (i_sts.child_nz) begin
                    if (i_sts.out_free) begin
                        cmd.commit_hit = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else if (i_sts.at_end) begin
                    if (i_sts.out_free) begin
                        cmd.commit_miss = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    // null child under a present key: keep scanning
                    cmd.step = 1'b1;
                    n_state  = S_INDEX;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_cmd      = cmd;

endmodule

// ----- rtl/rn48_dp.sv -----
// datapath of the node48 child table: key index, slot store, counters, result register
module rn48_dp #(
    parameter int SLOTS    = rn48_pkg::SLOTS_DEF,
    parameter int MIN_FILL = rn48_pkg::MIN_FILL_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rn48_pkg::t_cmd                    i_cmd,
    input  logic [rn48_pkg::OP_W-1:0]         i_op,
    input  logic [rn48_pkg::KEY_W-1:0]        i_key,
    input  logic [rn48_pkg::CHILD_W-1:0]      i_child,
    input  logic                              i_force,
    input  logic                              i_out_ready,
    output rn48_pkg::t_sts                    o_sts,
    output logic                              o_out_valid,
    output logic [rn48_pkg::STATUS_W-1:0]     o_status,
    output logic                              o_found,
    output logic [rn48_pkg::KEY_W-1:0]        o_found_key,
    output logic [rn48_pkg::CHILD_W-1:0]      o_found_child
);
    import rn48_pkg::*;

    localparam int IX_W = $clog2(SLOTS + 1);
    localparam int SA_W = $clog2(SLOTS);
    localparam logic [IX_W-1:0] IX_EMPTY = IX_W'(SLOTS);

    // key index and slot store
    logic [IX_W-1:0]    key_mem  [KEY_SPACE];
    logic [CHILD_W-1:0] slot_mem [SLOTS];
    logic [KEY_SPACE-1:0] r_valid;

    logic [OP_W-1:0]    r_op;
    logic [KEY_W-1:0]   r_cur;
    logic [KEY_W-1:0]   n_cur;
    logic [CHILD_W-1:0] r_child;
    logic               r_force;
    logic [IX_W-1:0]    r_ix_q;
    logic               r_ixv_q;
    logic [CHILD_W-1:0] r_slot_q;
    logic [IX_W-1:0]    r_slots_used;
    logic [IX_W-1:0]    r_live;

    logic               r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic               r_found;
    logic [KEY_W-1:0]   r_found_key;
    logic [CHILD_W-1:0] r_found_child;

    logic               present;
    logic               at_end;
    logic               point_op;
    logic               full;
    logic               out_free;

    logic               slot_we;
    logic [SA_W-1:0]    slot_wa;
    logic [CHILD_W-1:0] slot_wd;
    logic               idx_we;
    logic [IX_W-1:0]    idx_wd;
    logic               used_inc;
    logic               live_inc;
    logic               live_dec;
    t_status            pt_status;

    assign present  = r_ixv_q && (r_ix_q != IX_EMPTY);
    assign full     = (r_slots_used >= IX_EMPTY);
    assign out_free = !r_out_valid || i_out_ready;
    assign point_op = !((r_op == OP_LOOKUP) || (r_op == OP_MIN_GE) || (r_op == OP_MAX_LE));
    assign at_end   = (r_op == OP_LOOKUP)
                   || ((r_op == OP_MIN_GE) && (r_cur == {KEY_W{1'b1}}))
                   || ((r_op == OP_MAX_LE) && (r_cur == '0));

    always_comb begin
        if (i_cmd.load) begin
            n_cur = i_key;
        end else if (i_cmd.step) begin
            n_cur = (r_op == OP_MAX_LE) ? r_cur - KEY_W'(1) : r_cur + KEY_W'(1);
        end else begin
            n_cur = r_cur;
        end
    end

    // effect of insert, change and remove, applied on commit
    always_comb begin
        slot_we   = 1'b0;
        slot_wa   = r_ix_q[SA_W-1:0];
        slot_wd   = r_child;
        idx_we    = 1'b0;
        idx_wd    = r_slots_used;
        used_inc  = 1'b0;
        live_inc  = 1'b0;
        live_dec  = 1'b0;
        pt_status = STAT_OK;
        case (r_op)
            OP_INSERT: begin
                if (present) begin
                    slot_we = 1'b1;
                end else if (full) begin
                    pt_status = STAT_FULL;
                end else begin
                    slot_we  = 1'b1;
                    slot_wa  = r_slots_used[SA_W-1:0];
                    idx_we   = 1'b1;
                    used_inc = 1'b1;
                    live_inc = 1'b1;
                end
            end
            OP_CHANGE: begin
                if (present) begin
                    slot_we = 1'b1;
                end else begin
                    pt_status = STAT_ABSENT;
                end
            end
            OP_REMOVE: begin
                // minimum fill is checked before the key
                if ((r_live == IX_W'(MIN_FILL)) && !r_force) begin
                    pt_status = STAT_MIN_FILL;
                end else if (!present) begin
                    pt_status = STAT_ABSENT;
                end else begin
                    slot_we  = 1'b1;
                    slot_wd  = '0;
                    idx_we   = 1'b1;
                    idx_wd   = IX_EMPTY;
                    live_dec = (r_live != '0);
                end
            end
            default: begin
                pt_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_point && slot_we) begin
            slot_mem[slot_wa] <= slot_wd;
        end
        r_slot_q <= slot_mem[r_ix_q[SA_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_point && idx_we) begin
            key_mem[r_cur] <= idx_wd;
        end
        r_ix_q <= key_mem[n_cur];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.commit_point && idx_we) begin
            r_valid[r_cur] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ixv_q <= r_valid[n_cur];
        r_cur   <= n_cur;
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_child <= i_child;
            r_force <= i_force;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slots_used <= '0;
            r_live       <= '0;
        end else if (i_cmd.commit_point) begin
            if (used_inc) begin
                r_slots_used <= r_slots_used + IX_W'(1);
            end
            if (live_inc) begin
                r_live <= r_live + IX_W'(1);
            end else if (live_dec) begin
                r_live <= r_live - IX_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit_point || i_cmd.commit_hit || i_cmd.commit_miss) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit_point) begin
            r_status      <= pt_status;
            r_found       <= 1'b0;
            r_found_key   <= '0;
            r_found_child <= '0;
        end else if (i_cmd.commit_hit) begin
            r_status      <= STAT_OK;
            r_found       <= 1'b1;
            r_found_key   <= r_cur;
            r_found_child <= r_slot_q;
        end else if (i_cmd.commit_miss) begin
            r_status      <= STAT_ABSENT;
            r_found       <= 1'b0;
            r_found_key   <= '0;
            r_found_child <= '0;
        end
    end

    assign o_sts.point_op = point_op;
    assign o_sts.present  = present;
    assign o_sts.at_end   = at_end;
    assign o_sts.child_nz = (r_slot_q != '0);
    assign o_sts.out_free = out_free;

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_found_key   = r_found_key;
    assign o_found_child = r_found_child;

endmodule

// ----- rtl/rn48_chk.sv -----
// port-level checks of the node48 child table, bound to the top level
module rn48_chk (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [rn48_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rn48_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed or dropped while stalled");

    // one item in work at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    // a found child always comes with status ok and a non-null reference
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[STATUS_W] |->
            (m_axis_tdata[STATUS_W-1:0] == STAT_OK)
            && (m_axis_tdata[STATUS_W + 1 + KEY_W +: CHILD_W] != '0))
        else $error("found result with bad status or null child");

    // no find leaves key and child zero
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[STATUS_W] |->
            (m_axis_tdata[OUT_TDATA_W-1:STATUS_W + 1] == '0))
        else $error("result without a find carries key or child");

    // reset leaves the block idle with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && s_axis_tready)
        else $error("block not idle after reset");

endmodule

bind radix_node48_child_table rn48_chk u_rn48_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- test/tb_radix_node48_child_table.sv -----
// self-checking testbench of the node48 child table
`timescale 1ns / 100ps

module tb_radix_node48_child_table;
    import rn48_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEMS_PER_PHASE = 282;
    localparam int DRAIN_CYCLES   = 40;
    localparam logic [5:0] EMPTY_SLOT = 6'(SLOTS_DEF);
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;
    localparam logic [CHILD_W-1:0] CHILD_ONES = '1;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [KEY_W-1:0]    fkey;
        logic [CHILD_W-1:0]  fchild;
    } t_node_result;

    class node48_scoreboard;
        logic [5:0]          key_slot [KEY_SPACE];
        logic [CHILD_W-1:0]  slot_child [SLOTS_DEF];
        int unsigned         slots_taken;
        int unsigned         live_children;
        t_node_result        pending_results [$];
        int                  errors;

        function new();
            foreach (key_slot[k]) key_slot[k] = EMPTY_SLOT;
            foreach (slot_child[s]) slot_child[s] = '0;
            slots_taken   = 0;
            live_children = 0;
            errors        = 0;
        endfunction

        // update the table copy and queue the result this item must produce
        function void note_item(logic [2:0] op, logic [KEY_W-1:0] key,
                                logic [CHILD_W-1:0] child, logic force_req);
            t_node_result r;
            int k;
            int stp;
            logic hit;
            r   = '0;
            hit = (key_slot[key] != EMPTY_SLOT);
            case (op)
                OP_INSERT: begin
                    if (hit) begin
                        slot_child[key_slot[key]] = child;
                    end else if (slots_taken >= SLOTS_DEF) begin
                        r.status = STAT_FULL;
                    end else begin
                        slot_child[slots_taken] = child;
                        key_slot[key] = 6'(slots_taken);
                        slots_taken++;
                        live_children++;
                    end
                end
                OP_CHANGE: begin
                    if (hit) slot_child[key_slot[key]] = child;
                    else r.status = STAT_ABSENT;
                end
                OP_REMOVE: begin
                    // minimum fill is tested before the key
                    if (live_children == MIN_FILL_DEF && !force_req) begin
                        r.status = STAT_MIN_FILL;
                    end else if (!hit) begin
                        r.status = STAT_ABSENT;
                    end else begin
                        slot_child[key_slot[key]] = '0;
                        key_slot[key] = EMPTY_SLOT;
                        if (live_children > 0) live_children--;
                    end
                end
                OP_LOOKUP: begin
                    if (hit && slot_child[key_slot[key]] != '0) begin
                        r.found  = 1'b1;
                        r.fkey   = key;
                        r.fchild = slot_child[key_slot[key]];
                    end else begin
                        r.status = STAT_ABSENT;
                    end
                end
                OP_MIN_GE, OP_MAX_LE: begin
                    r.status = STAT_ABSENT;
                    stp = (op == OP_MIN_GE) ? 1 : -1;
                    for (k = int'(key); k >= 0 && k < KEY_SPACE; k += stp) begin
                        if (key_slot[k] != EMPTY_SLOT && slot_child[key_slot[k]] != '0) begin
                            r.status = STAT_OK;
                            r.found  = 1'b1;
                            r.fkey   = KEY_W'(k);
                            r.fchild = slot_child[key_slot[k]];
                            break;
                        end
                    end
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data);
            t_node_result want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result item %h", $time, data);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (data[1:0] !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, data[1:0]);
                errors++;
            end
            if (data[2] !== want.found) begin
                $display("%0t: found expected %0d actual %0d", $time, want.found, data[2]);
                errors++;
            end
            if (data[10:3] !== want.fkey) begin
                $display("%0t: found_key expected %0d actual %0d", $time, want.fkey,
                         data[10:3]);
                errors++;
            end
            if (data[58:11] !== want.fchild) begin
                $display("%0t: found_child expected %h actual %h", $time, want.fchild,
                         data[58:11]);
                errors++;
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata;
    logic [OP_W-1:0]          s_axis_tuser;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;

    node48_scoreboard results;
    int               send_idle_pct;
    int               recv_stall_pct;
    bit               hold_req;
    int               quiet_cycles;
    logic [KEY_W-1:0] key_pool [$];

    radix_node48_child_table dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // one item offered per call, idle gaps first
    task automatic send_item(logic [2:0] op, logic [KEY_W-1:0] key,
                             logic [CHILD_W-1:0] child, logic force_req);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, force_req, child, key};
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_INSERT) key_pool.push_back(key);
    endtask

    task automatic send_random_item();
        int r;
        logic [2:0]         op;
        logic [KEY_W-1:0]   key;
        logic [CHILD_W-1:0] child;
        r = $urandom_range(0, 99);
        if (r < 28)      op = OP_INSERT;
        else if (r < 40) op = OP_CHANGE;
        else if (r < 55) op = OP_REMOVE;
        else if (r < 72) op = OP_LOOKUP;
        else if (r < 84) op = OP_MIN_GE;
        else if (r < 96) op = OP_MAX_LE;
        else             op = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
        r = $urandom_range(0, 99);
        if (key_pool.size() != 0 && r < 55)
            key = key_pool[$urandom_range(0, key_pool.size() - 1)];
        else if (r < 60)
            key = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        else
            key = KEY_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 10)      child = '0;
        else if (r < 15) child = CHILD_ONES;
        else             child = CHILD_W'({$urandom, $urandom});
        send_item(op, key, child, $urandom_range(0, 99) < 15);
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                results.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[55:8],
                                  s_axis_tdata[56]);
            if (m_axis_tvalid && m_axis_tready)
                results.check_result(m_axis_tdata);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        results        = new();
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        quiet_cycles   = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty table, extremes, null child, replace, absent keys
        send_item(OP_LOOKUP, 8'd0,   '0, 1'b0);
        send_item(OP_MIN_GE, 8'd0,   '0, 1'b0);
        send_item(OP_MAX_LE, 8'd255, '0, 1'b0);
        send_item(OP_REMOVE, 8'd5,   '0, 1'b0);
        send_item(OP_CHANGE, 8'd7,   48'h0000_0000_0007, 1'b0);
        send_item(OP_INSERT, 8'd0,   CHILD_ONES, 1'b0);
        send_item(OP_INSERT, 8'd255, '0, 1'b0);
        send_item(OP_INSERT, 8'd128, 48'h0000_0000_0001, 1'b0);
        send_item(OP_LOOKUP, 8'd0,   '0, 1'b0);
        send_item(OP_LOOKUP, 8'd255, '0, 1'b0);
        send_item(OP_MIN_GE, 8'd1,   '0, 1'b0);
        send_item(OP_MIN_GE, 8'd129, '0, 1'b0);
        send_item(OP_MAX_LE, 8'd255, '0, 1'b0);
        send_item(OP_MAX_LE, 8'd127, '0, 1'b0);
        send_item(OP_MIN_GE, 8'd0,   '0, 1'b0);
        send_item(OP_INSERT, 8'd0,   48'h5555_5555_5555, 1'b0);
        send_item(OP_CHANGE, 8'd128, 48'hAAAA_AAAA_AAAA, 1'b0);
        send_item(OP_CHANGE, 8'd255, 48'h1234_5678_9ABC, 1'b0);
        send_item(OP_MIN_GE, 8'd129, '0, 1'b0);
        send_item(OP_REMOVE, 8'd128, '0, 1'b1);
        send_item(OP_LOOKUP, 8'd128, '0, 1'b0);
        send_item(OP_REMOVE, 8'd128, '0, 1'b0);
        send_item(OP_SPARE_A, 8'd255, CHILD_ONES, 1'b1);
        send_item(OP_SPARE_B, 8'd255, CHILD_ONES, 1'b1);
        send_item(OP_INSERT, 8'd128, 48'h8000_0000_0000, 1'b0);
        send_item(OP_MAX_LE, 8'd0,   '0, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // long receiver hold-off while items keep coming
                if (ph == 0 && n == 100) hold_req = 1'b1;
                send_random_item();
            end
        end

        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (results.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (results.errors == 0 && results.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rn48_pkg.sv
rtl/rn48_ctrl.sv
rtl/rn48_dp.sv
rtl/radix_node48_child_table.sv
rtl/rn48_chk.sv
test/tb_radix_node48_child_table.sv
